FILE: rtl/mi3_pkg.sv
package mi3_pkg;

  // Default entry format: signed Q16.16
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Matrix size
  localparam int NUM_ENTRIES = 9;

endpackage

FILE: rtl/matrix3x3_inverse_core.sv
// 3x3 matrix inverse, one matrix per beat, fully pipelined. The block computes
// the cofactors and the exact determinant, then divides each transposed
// cofactor, scaled by 2^(2*FRAC_BITS), by the determinant. Results are
// truncated toward zero and saturated to the entry format. A zero determinant
// sets out_tuser (singular) and zeroes all entries and the determinant field.
// Throughput is one matrix per clock while the output is not stalled. The
// depth is set by the nine restoring dividers, which resolve one quotient
// bit per stage. The pipeline collapses bubbles on a stall, so input is
// taken while free stages remain.
module matrix3x3_inverse_core #(
  parameter int ENTRY_WIDTH = mi3_pkg::ENTRY_WIDTH_DEF,
  parameter int FRAC_BITS   = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // entry_r0c0, entry_r0c1, ... entry_r2c2, ENTRY_WIDTH bits each, zero pad
  input  logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // inv_r0c0 ... inv_r2c2, determinant, ENTRY_WIDTH bits each, zero pad
  output logic [((10*ENTRY_WIDTH+7)/8)*8-1:0] out_tdata,
  // singular
  output logic out_tuser
);

  localparam int E     = ENTRY_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int NE    = mi3_pkg::NUM_ENTRIES;
  localparam int PW    = 2*E;          // two-entry product
  localparam int CW    = 2*E + 1;      // cofactor
  localparam int HW    = 2*E + 1;      // partial product of determinant
  localparam int DW    = 3*E + 3;      // determinant
  localparam int NW    = 2*E + 1 + 2*F;  // scaled numerator magnitude
  localparam int WW    = ((NW > DW + E) ? NW : DW + E) + 1;
  localparam int OW    = ((10*E+7)/8)*8;
  localparam int NST   = E + 7;        // pipeline stages incl. output
  localparam int SDIV  = 5;            // first divider stage index

  localparam logic [DW-1:0] HALF_D = DW'(1) << (E-1);
  localparam logic [E-1:0]  HALF_E = E'(1) << (E-1);
  localparam logic [E-1:0]  MAX_E  = HALF_E - E'(1);
  localparam logic [E-1:0]  MIN_E  = HALF_E;

  // stage valids and enables
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int k = NST-2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // input unpack
  logic signed [E-1:0] m [NE];
  always_comb begin
    for (int k = 0; k < NE; k++) m[k] = $signed(in_tdata[k*E +: E]);
  end

  // stage 0: cofactor products
  logic signed [PW-1:0] pa_r [NE];
  logic signed [PW-1:0] pb_r [NE];
  logic signed [E-1:0]  row0_r [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pa_r[i*3+j] <= m[((j+1)%3)*3 + (i+1)%3] * m[((j+2)%3)*3 + (i+2)%3];
          pb_r[i*3+j] <= m[((j+1)%3)*3 + (i+2)%3] * m[((j+2)%3)*3 + (i+1)%3];
        end
      end
      for (int k = 0; k < 3; k++) row0_r[k] <= m[k];
    end
  end

  // stage 1: adjugate
  logic signed [CW-1:0] adj1_r [NE];
  logic signed [E-1:0]  row1_r [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < NE; k++) adj1_r[k] <= CW'(pa_r[k]) - CW'(pb_r[k]);
      for (int k = 0; k < 3; k++) row1_r[k] <= row0_r[k];
    end
  end

  // stage 2: determinant partial products along row 0
  logic signed [HW-1:0] plo_r [3];
  logic signed [HW-1:0] phi_r [3];
  logic signed [CW-1:0] adj2_r [NE];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        plo_r[k] <= row1_r[k] * $signed({1'b0, adj1_r[k*3][E-1:0]});
        phi_r[k] <= row1_r[k] * $signed(adj1_r[k*3][CW-1:E]);
      end
      for (int k = 0; k < NE; k++) adj2_r[k] <= adj1_r[k];
    end
  end

  // stage 3: determinant sum
  logic signed [DW-1:0] det_r;
  logic signed [CW-1:0] adj3_r [NE];
  logic signed [DW-1:0] det_nxt;

  always_comb begin
    det_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      det_nxt = det_nxt + (DW'(phi_r[k]) <<< E) + DW'(plo_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      det_r <= det_nxt;
      for (int k = 0; k < NE; k++) adj3_r[k] <= adj2_r[k];
    end
  end

  // stage 4: magnitudes, signs, determinant output
  logic [DW-1:0] dmag4_r;
  logic [NW-1:0] nmag4_r [NE];
  logic          neg4_r [NE];
  logic          sing4_r;
  logic [E-1:0]  detq4_r;

  logic [DW-1:0] dmag_nxt;
  logic [DW-1:0] dsh_nxt;
  logic [E-1:0]  detq_nxt;
  logic [CW-1:0] amag_nxt [NE];

  always_comb begin
    dmag_nxt = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    dsh_nxt  = dmag_nxt >> (2*F);
    if (!det_r[DW-1]) begin
      detq_nxt = (dsh_nxt >= HALF_D) ? MAX_E : dsh_nxt[E-1:0];
    end else begin
      detq_nxt = (dsh_nxt > HALF_D) ? MIN_E : E'(-dsh_nxt[E-1:0]);
    end
    for (int k = 0; k < NE; k++) begin
      amag_nxt[k] = adj3_r[k][CW-1] ? CW'(-adj3_r[k]) : CW'(adj3_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      dmag4_r <= dmag_nxt;
      sing4_r <= (det_r == '0);
      detq4_r <= detq_nxt;
      for (int k = 0; k < NE; k++) begin
        nmag4_r[k] <= NW'(amag_nxt[k]) << (2*F);
        neg4_r[k]  <= adj3_r[k][CW-1] ^ det_r[DW-1];
      end
    end
  end

  // divider: stage 0 checks overflow, stages 1..E each resolve one quotient bit
  logic [WW-1:0] rem_r  [E+1][NE];
  logic [E-1:0]  q_r    [E+1][NE];
  logic          ovf_r  [E+1][NE];
  logic          neg_r  [E+1][NE];
  logic [DW-1:0] dmag_r [E+1];
  logic          sing_r [E+1];
  logic [E-1:0]  detq_r [E+1];

  always_ff @(posedge clk) begin
    if (en[SDIV]) begin
      dmag_r[0] <= dmag4_r;
      sing_r[0] <= sing4_r;
      detq_r[0] <= detq4_r;
      for (int k = 0; k < NE; k++) begin
        rem_r[0][k] <= WW'(nmag4_r[k]);
        q_r[0][k]   <= '0;
        ovf_r[0][k] <= WW'(nmag4_r[k]) >= (WW'(dmag4_r) << E);
        neg_r[0][k] <= neg4_r[k];
      end
    end
  end

  for (genvar d = 1; d <= E; d++) begin : g_div
    localparam int B = E - d;
    logic [WW-1:0] sub_w [NE];
    logic          ge_w  [NE];
    logic [E-1:0]  qn_w  [NE];

    always_comb begin
      for (int k = 0; k < NE; k++) begin
        ge_w[k]  = rem_r[d-1][k] >= (WW'(dmag_r[d-1]) << B);
        sub_w[k] = rem_r[d-1][k] - (WW'(dmag_r[d-1]) << B);
        qn_w[k]    = q_r[d-1][k];
        qn_w[k][B] = ge_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[SDIV+d]) begin
        dmag_r[d] <= dmag_r[d-1];
        sing_r[d] <= sing_r[d-1];
        detq_r[d] <= detq_r[d-1];
        for (int k = 0; k < NE; k++) begin
          rem_r[d][k]    <= ge_w[k] ? sub_w[k] : rem_r[d-1][k];
          q_r[d][k]      <= qn_w[k];
          ovf_r[d][k]    <= ovf_r[d-1][k];
          neg_r[d][k]    <= neg_r[d-1][k];
        end
      end
    end
  end

  // output stage: sign, saturate, pack
  logic [OW-1:0] outd_r;
  logic          outu_r;
  logic [OW-1:0] outd_nxt;
  logic [E-1:0]  res_nxt [NE];

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (sing_r[E]) begin
        res_nxt[k] = '0;
      end else if (!neg_r[E][k]) begin
        res_nxt[k] = (ovf_r[E][k] || q_r[E][k][E-1]) ? MAX_E : q_r[E][k];
      end else begin
        res_nxt[k] = (ovf_r[E][k] || (q_r[E][k] > HALF_E)) ? MIN_E : E'(-q_r[E][k]);
      end
    end
    outd_nxt = '0;
    for (int k = 0; k < NE; k++) outd_nxt[k*E +: E] = res_nxt[k];
    outd_nxt[NE*E +: E] = sing_r[E] ? '0 : detq_r[E];
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      outd_r <= outd_nxt;
      outu_r <= sing_r[E];
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = outd_r;
  assign out_tuser  = outu_r;

  // a singular beat carries all-zero data
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("singular beat with nonzero data");

  // an accepted beat lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat lost at entry");

  // input backpressure only when every stage holds a beat
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && !out_tready)
    else $error("input stalled with free stage");

endmodule

FILE: tb/matrix_inverse_checker.sv
`timescale 1ns / 1ps

module matrix_inverse_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [287:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [319:0] out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending_count
);

  localparam int EW = mi3_pkg::ENTRY_WIDTH_DEF;
  localparam int FB = mi3_pkg::FRAC_BITS_DEF;

  typedef logic signed [255:0] big_t;

  typedef struct packed {
    logic [9:0][EW-1:0] words;  // nine inverse entries, then determinant
    logic               singular;
  } inverse_beat_t;

  inverse_beat_t inverse_q[$];

  // Clamp an exact value to the signed entry range
  function automatic logic [EW-1:0] clamp_entry(big_t v);
    big_t hi_lim;
    big_t lo_lim;
    hi_lim = (big_t'(1) <<< (EW - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) return hi_lim[EW-1:0];
    if (v < lo_lim) return lo_lim[EW-1:0];
    return v[EW-1:0];
  endfunction

  // Exact adjugate / determinant; division truncates toward zero
  function automatic inverse_beat_t invert_matrix(logic [287:0] d);
    big_t m [3][3];
    big_t det;
    big_t cof;
    logic signed [EW-1:0] e;
    inverse_beat_t r;
    det = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        e = d[(i*3+j)*EW +: EW];
        m[i][j] = e;
      end
    for (int k = 0; k < 3; k++) begin
      det = det + m[0][k] * m[1][(k+1)%3] * m[2][(k+2)%3];
      det = det - m[0][k] * m[1][(k+2)%3] * m[2][(k+1)%3];
    end
    r.singular = (det == 0);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        cof = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
            - m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
        r.words[i*3+j] = r.singular ? '0 : clamp_entry((cof <<< (2*FB)) / det);
      end
    r.words[9] = r.singular ? '0 : clamp_entry(det / (big_t'(1) <<< (2*FB)));
    return r;
  endfunction

  assign pending_count = inverse_q.size();

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    inverse_beat_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        inverse_q.push_back(invert_matrix(in_tdata));
      if (out_tvalid && out_tready) begin
        if (inverse_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected output beat %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = inverse_q.pop_front();
          if (want.words !== out_tdata || want.singular !== out_tuser) begin
            if (fail_count < 10) begin
              $display("ERROR: mismatch");
              for (int k = 0; k < 10; k++)
                $display("  word %0d exp %h got %h", k, want.words[k],
                         out_tdata[k*EW +: EW]);
              $display("  singular exp %b got %b", want.singular, out_tuser);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int  EW       = mi3_pkg::ENTRY_WIDTH_DEF;
  localparam int  WD_LIMIT = 20000;
  localparam logic [EW-1:0] ONE  = 32'h0001_0000;
  localparam logic [EW-1:0] MAXV = 32'h7fff_ffff;
  localparam logic [EW-1:0] MINV = 32'h8000_0000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [319:0] out_tdata;
  logic         out_tuser;
  int           fail_count;
  int           pending_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           quiet_cycles = 0;

  matrix3x3_inverse_core u_top (.*);

  matrix_inverse_checker u_chk (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Random backpressure on the result side
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // One matrix beat, with random idle cycles ahead of it
  task automatic send_matrix(logic [8:0][EW-1:0] m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [EW-1:0] rand_entry();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return EW'($signed($urandom_range(8 * 65536)) - 4 * 65536);
      2:       return EW'($signed($urandom_range(512)) - 256);
      default: return EW'($signed($urandom_range(1 << 26)) - (1 << 25));
    endcase
  endfunction

  task automatic send_random(int n);
    logic [8:0][EW-1:0] m;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 9; k++) m[k] = rand_entry();
      // some singular ones: a repeated or zero row
      case ($urandom_range(9))
        0: for (int k = 0; k < 3; k++) m[3+k] = m[k];
        1: for (int k = 0; k < 3; k++) m[6+k] = '0;
        default: ;
      endcase
      send_matrix(m);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic [8:0][EW-1:0] m;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, zero, extremes, tiny and overflowing determinants
    m = '0; m[0] = ONE; m[4] = ONE; m[8] = ONE; send_matrix(m);
    m = '0; send_matrix(m);
    m = {9{MAXV}}; send_matrix(m);
    m = {9{MINV}}; send_matrix(m);
    m = '0; m[0] = MAXV; m[4] = MAXV; m[8] = MAXV; send_matrix(m);
    m = '0; m[0] = MINV; m[4] = MINV; m[8] = MINV; send_matrix(m);
    m = '0; m[0] = MINV; m[4] = MAXV; m[8] = MINV; send_matrix(m);
    m = '0; m[0] = 1; m[4] = 1; m[8] = 1; send_matrix(m);
    m = '0; m[0] = 32'hffff_ffff; m[4] = 1; m[8] = 1; send_matrix(m);
    m = '0; m[2] = ONE; m[4] = ONE; m[6] = ONE; send_matrix(m);
    m = '0; m[0] = 2 * ONE; m[4] = -(4 * ONE); m[8] = ONE / 2; send_matrix(m);
    m = '0; m[0] = 256; m[4] = 256; m[8] = 256; send_matrix(m);
    m = {9{ONE}}; send_matrix(m);
    m = '0; m[0] = MAXV; m[1] = MINV; m[3] = MINV; m[4] = MAXV; m[8] = ONE;
    send_matrix(m);
    m = '0; m[0] = 32'h5555_5555; m[4] = 32'haaaa_aaaa; m[8] = 32'h0000_ffff;
    send_matrix(m);
    drain();

    // Random phases with different idle and stall mixes
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(125); drain();
    send_idle_pct = 76; recv_stall_pct = 0;  send_random(125);
    send_idle_pct = 0;  recv_stall_pct = 76; send_random(125); drain();
    send_idle_pct = 19; recv_stall_pct = 19; send_random(125);

    drain();
    recv_stall_pct = 0;
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
